### src/assert_macros.svh
// Assertion macros shared by the rotation-to-Euler block.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

### src/rme_pkg.sv
// Package for the rotation-to-Euler block: widths, CORDIC angle table, helpers.
// Depends on nothing; used by every module in src.
package rme_pkg;
  localparam int ElementWidth = 18;
  localparam int AngleWidth = 21;
  localparam int CordicStages = 20;
  // Internal datapath width of CORDIC x and y.
  localparam int DataWidth = 38;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;

  typedef logic [31:0] angle_t;

  // Fixed stage angle table, 2^32 units per turn.
  function automatic angle_t atan_entry(input logic [4:0] idx);
    angle_t r;
    unique case (idx)
      5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Per-lane control carried alongside one CORDIC operand pair.
  typedef struct packed {
    logic       den_zero;
    logic [1:0] num_sign; // bit1 negative, bit0 positive
    logic       add_half;
  } lane_ctl_t;
endpackage

### src/rme_sqrt_cell.sv
// One cell of the restoring square root chain: one result bit per cycle while en is high.
// Depends on rme_pkg.
module rme_sqrt_cell import rme_pkg::*; #(
  parameter int W = 34,
  parameter int BitPos = 0
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] res_in,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] res_out
);
  localparam logic [W-1:0] Bit = W'(1) << (2 * BitPos);
  logic [W-1:0] trial;
  logic         take;

  // Compare the remainder against the trial value and update both.
  assign trial = res_in + Bit;
  assign take  = rem_in >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? rem_in - trial : rem_in;
      res_out <= take ? (res_in >> 1) + Bit : res_in >> 1;
    end
  end
endmodule

### src/rme_cordic_cell.sv
// One CORDIC vectoring cell for three lanes: one micro-rotation per cycle while en is high.
// Depends on rme_pkg.
module rme_cordic_cell import rme_pkg::*; #(
  parameter int Shift = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [DataWidth-1:0] x_in [3],
  input  logic signed [DataWidth-1:0] y_in [3],
  input  angle_t                      z_in [3],
  output logic signed [DataWidth-1:0] x_out [3],
  output logic signed [DataWidth-1:0] y_out [3],
  output angle_t                      z_out [3]
);
  localparam angle_t Step = atan_entry(5'(Shift % 32));

  // Rotate each lane towards the x axis; arithmetic shifts floor.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (!y_in[k][DataWidth-1]) begin
          x_out[k] <= x_in[k] + (y_in[k] >>> Shift);
          y_out[k] <= y_in[k] - (x_in[k] >>> Shift);
          z_out[k] <= z_in[k] + Step;
        end else begin
          x_out[k] <= x_in[k] - (y_in[k] >>> Shift);
          y_out[k] <= y_in[k] + (x_in[k] >>> Shift);
          z_out[k] <= z_in[k] - Step;
        end
      end
    end
  end
endmodule

### src/rotation_matrix_to_euler_angles_top.sv
// Rotation matrix to Euler angles: elastic pipeline of sqrt and CORDIC cells.
// Depends on rme_pkg, rme_sqrt_cell, rme_cordic_cell and assert_macros.svh.
//
// Input channel: mode and eight matrix entries (Q2.16 at default width),
// accepted when in_valid is high and in_stall is low. Output channel: three
// binary angles, taken when out_valid is high and out_stall is low.
// One transaction enters every cycle while in_stall is low. A register picks the
// operands, a square-root chain of one cell per result bit forms the cosine, then
// a row of CORDIC cells resolves three atan terms and a last register rounds them.
// The whole pipeline advances together; when out_stall is high with a
// result waiting, every stage holds and in_stall rises.
// Reset clears the valid bits only; no pipeline contents are cleared.
`include "assert_macros.svh"
module rotation_matrix_to_euler_angles_top import rme_pkg::*; #(
  parameter int ELEMENT_WIDTH = ElementWidth,
  parameter int ANGLE_WIDTH = AngleWidth,
  parameter int CORDIC_STAGES = CordicStages
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_11,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_12,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_13,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_21,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_22,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_31,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_32,
  input  logic signed [ELEMENT_WIDTH-1:0] mat_33,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ANGLE_WIDTH-1:0]          angle_x,
  output logic [ANGLE_WIDTH-1:0]          angle_y,
  output logic [ANGLE_WIDTH-1:0]          angle_z
);
  localparam int EW = ELEMENT_WIDTH;
  localparam int Half = EW - 1;          // bits of |s| <= ONE
  localparam int SqW = 2 * EW - 2;       // ONE^2 fits
  localparam int SqBits = (SqW + 1) / 2; // sqrt result bits
  localparam int Scale = 33 - EW;
  localparam int NumStages = 1 + SqBits + 1 + CORDIC_STAGES + 1;
  localparam logic signed [EW:0] One = (EW + 1)'(1) <<< (EW - 2);

  logic adv;
  logic [NumStages-1:0] vld;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NumStages-1];

  // Valid bits shift with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], in_valid};
    end
  end

  // Stage 0: pick operands for the mode and saturate the asin argument.
  logic signed [EW:0] s0, n1_0, d1_0, n2_0, d2_0;
  logic               m0;
  logic signed [EW:0] ss;
  always_comb begin
    ss = mode ? -(EW + 1)'(mat_31) : -(EW + 1)'(mat_12);
    if (ss > One) ss = One;
    if (ss < -One) ss = -One;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m0 <= mode;
      s0 <= ss;
      n1_0 <= mode ? -(EW + 1)'(mat_32) : (EW + 1)'(mat_13);
      d1_0 <= mode ? (EW + 1)'(mat_33) : (EW + 1)'(mat_11);
      n2_0 <= mode ? -(EW + 1)'(mat_21) : (EW + 1)'(mat_32);
      d2_0 <= mode ? (EW + 1)'(mat_11) : (EW + 1)'(mat_22);
    end
  end

  // Square-root chain: operands travel beside the remainder.
  logic [SqW-1:0] rem [SqBits+1];
  logic [SqW-1:0] res [SqBits+1];
  logic signed [EW:0] sd [SqBits+1][5];
  logic               md [SqBits+1];
  logic [Half-1:0] sabs;
  assign sabs = Half'(s0[EW] ? -s0 : s0);
  assign rem[0] = SqW'(One) * SqW'(One) - SqW'(sabs) * SqW'(sabs);
  assign res[0] = '0;
  assign sd[0] = '{s0, n1_0, d1_0, n2_0, d2_0};
  assign md[0] = m0;

  for (genvar g = 0; g < SqBits; g++) begin : g_sqrt
    rme_sqrt_cell #(.W(SqW), .BitPos(SqBits - 1 - g)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem[g]), .res_in(res[g]),
      .rem_out(rem[g+1]), .res_out(res[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sd[g+1] <= sd[g];
        md[g+1] <= md[g];
      end
    end
  end

  // Prepare three CORDIC lanes: asin term, then the two atan terms.
  logic signed [DataWidth-1:0] cx [CORDIC_STAGES+1][3];
  logic signed [DataWidth-1:0] cy [CORDIC_STAGES+1][3];
  angle_t                      cz [CORDIC_STAGES+1][3];
  lane_ctl_t                   cc [CORDIC_STAGES+1][3];
  logic                        cm [CORDIC_STAGES+1];
  logic signed [EW:0] num [3];
  logic signed [EW:0] den [3];
  logic               cpos;
  assign cpos = res[SqBits] != '0;
  assign num[0] = sd[SqBits][0];
  assign den[0] = (EW + 1)'(res[SqBits]);
  assign num[1] = sd[SqBits][1];
  assign den[1] = sd[SqBits][2];
  assign num[2] = sd[SqBits][3];
  assign den[2] = sd[SqBits][4];

  always_ff @(posedge clk) begin
    if (adv) begin
      cm[0] <= md[SqBits];
      for (int k = 0; k < 3; k++) begin
        cc[0][k].den_zero <= den[k] == '0;
        cc[0][k].num_sign <= {num[k][EW], num[k] != '0 && !num[k][EW]};
        cc[0][k].add_half <= (k != 0) && !(den[k] > 0 && cpos);
        cz[0][k] <= '0;
        if (den[k][EW]) begin
          cx[0][k] <= DataWidth'(-den[k]) <<< Scale;
          cy[0][k] <= DataWidth'(-num[k]) <<< Scale;
        end else begin
          cx[0][k] <= DataWidth'(den[k]) <<< Scale;
          cy[0][k] <= DataWidth'(num[k]) <<< Scale;
        end
      end
    end
  end

  // Row of CORDIC cells.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rme_cordic_cell #(.Shift(g)) u_cell (
      .clk(clk), .en(adv),
      .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
      .x_out(cx[g+1]), .y_out(cy[g+1]), .z_out(cz[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        cc[g+1] <= cc[g];
        cm[g+1] <= cm[g];
      end
    end
  end

  // Final stage: special cases, half turn, rounding, and angle routing.
  angle_t fin [3];
  logic [ANGLE_WIDTH-1:0] rnd [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_ctl_t c;
      c = cc[CORDIC_STAGES][k];
      if (c.den_zero) begin
        fin[k] = c.num_sign[0] ? QuarterTurn : (c.num_sign[1] ? -QuarterTurn : '0);
      end else begin
        fin[k] = cz[CORDIC_STAGES][k];
      end
      if (c.add_half) fin[k] = fin[k] + HalfTurn;
      rnd[k] = ANGLE_WIDTH'((33'(fin[k]) + 33'((64'(1) << (32 - ANGLE_WIDTH)) >> 1))
                            >> (32 - ANGLE_WIDTH));
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (cm[CORDIC_STAGES]) begin
        angle_y <= rnd[0]; angle_x <= rnd[1]; angle_z <= rnd[2];
      end else begin
        angle_z <= rnd[0]; angle_y <= rnd[1]; angle_x <= rnd[2];
      end
    end
  end

  `ASSERT_IMP(a_stall_only_when_held, clk, rst, in_stall, out_valid && out_stall)
  `ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(angle_x))
  `ASSERT_NEXT(a_flow, clk, rst, !in_stall && in_valid, vld[0])
endmodule

### verif/rotation_matrix_to_euler_angles_top_test.sv
// Testbench for the rotation-matrix-to-Euler-angles block: directed and random matrices,
// each result checked against a bit-accurate CORDIC predictor kept in this file.
// Depends on rme_pkg and rotation_matrix_to_euler_angles_top.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_angles_top_test;
  import rme_pkg::*;

  localparam int EW = ElementWidth;
  localparam int AW = AngleWidth;
  localparam int Latency = 40;
  localparam int CycleLimit = 200000;
  localparam int RandomItems = 450;
  localparam logic ModeXzy = 1'b0;
  localparam logic ModeZyx = 1'b1;
  localparam logic [EW-1:0] One = 18'sd65536;
  localparam logic [EW-1:0] MinEl = 18'h20000;
  localparam logic [EW-1:0] MaxEl = 18'h1FFFF;

  typedef struct {
    logic          mode;
    logic [EW-1:0] m11, m12, m13, m21, m22, m31, m32, m33;
  } matrix_t;

  typedef struct {
    logic [AW-1:0] ax, ay, az;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic mode = 1'b0;
  logic signed [EW-1:0] mat_11 = '0, mat_12 = '0, mat_13 = '0, mat_21 = '0;
  logic signed [EW-1:0] mat_22 = '0, mat_31 = '0, mat_32 = '0, mat_33 = '0;
  logic [AW-1:0] angle_x, angle_y, angle_z;

  angles_t pending_angles[$];
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  bit quiet_stretch = 0;

  rotation_matrix_to_euler_angles_top uut (.*);

  always #5 clk = ~clk;

  // Clock watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[rotation_matrix_to_euler_angles_top] ERROR");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int sh);
    return v >>> sh;
  endfunction

  // Principal atan(num/den) as a 32-bit binary angle, CORDIC vectoring.
  function automatic logic [31:0] cordic_atan(longint num, longint den);
    longint x, y, z, dx, dy;
    if (den == 0) begin
      if (num > 0) return QuarterTurn;
      if (num < 0) return 32'h0 - QuarterTurn;
      return 32'h0;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    x = den <<< (33 - EW);
    y = num <<< (33 - EW);
    z = 0;
    for (int i = 0; i < CordicStages; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
      end
    end
    return z[31:0];
  endfunction

  // Round half up from 32-bit angle to output width.
  function automatic logic [AW-1:0] round_angle(logic [31:0] a);
    logic [32:0] v;
    v = {1'b0, a} + (33'd1 << (32 - AW - 1));
    return v[31 -: AW];
  endfunction

  // Expected Euler angles for one matrix.
  function automatic angles_t euler_of(matrix_t m);
    longint one, s, c, n1, d1, n2, d2;
    logic [31:0] a0, a1, a2;
    angles_t r;
    one = 64'sd1 <<< (EW - 2);
    if (m.mode == ModeXzy) begin
      s = -longint'($signed(m.m12));
      n1 = $signed(m.m13); d1 = $signed(m.m11);
      n2 = $signed(m.m32); d2 = $signed(m.m22);
    end else begin
      s = -longint'($signed(m.m31));
      n1 = -longint'($signed(m.m32)); d1 = $signed(m.m33);
      n2 = -longint'($signed(m.m21)); d2 = $signed(m.m11);
    end
    if (s > one) s = one;
    if (s < -one) s = -one;
    // Cosine by a coarse float estimate refined to the exact floor.
    c = longint'($sqrt(real'(one * one - s * s)));
    while (c * c > one * one - s * s) c--;
    while ((c + 1) * (c + 1) <= one * one - s * s) c++;
    a0 = cordic_atan(s, c);
    a1 = cordic_atan(n1, d1);
    if (!(d1 > 0 && c > 0)) a1 += HalfTurn;
    a2 = cordic_atan(n2, d2);
    if (!(d2 > 0 && c > 0)) a2 += HalfTurn;
    if (m.mode == ModeXzy) begin
      r.az = round_angle(a0); r.ay = round_angle(a1); r.ax = round_angle(a2);
    end else begin
      r.ay = round_angle(a0); r.ax = round_angle(a1); r.az = round_angle(a2);
    end
    return r;
  endfunction

  function automatic logic [EW-1:0] rand_el(bit near_unit);
    if (near_unit) return EW'($signed($urandom_range(0, 2 * 65536)) - 65536);
    return EW'($urandom);
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    bit unit;
    unit = ($urandom_range(0, 99) < 70);
    m.mode = 1'($urandom);
    m.m11 = rand_el(unit); m.m12 = rand_el(unit); m.m13 = rand_el(unit);
    m.m21 = rand_el(unit); m.m22 = rand_el(unit); m.m31 = rand_el(unit);
    m.m32 = rand_el(unit); m.m33 = rand_el(unit);
    // Now and then force a zero denominator or an exact unit entry.
    if ($urandom_range(0, 9) == 0) m.m11 = '0;
    if ($urandom_range(0, 9) == 0) m.m22 = '0;
    if ($urandom_range(0, 9) == 0) m.m33 = '0;
    if ($urandom_range(0, 12) == 0) m.m12 = $urandom_range(0, 1) ? One : -One;
    if ($urandom_range(0, 12) == 0) m.m31 = $urandom_range(0, 1) ? One : -One;
    return m;
  endfunction

  function automatic bit idle_now();
    return !quiet_stretch && ($urandom_range(0, 99) < 17);
  endfunction

  // Send one transaction and record its expected angles. Valid drops only
  // during idle cycles, so back-to-back transactions keep it high.
  task automatic send(matrix_t m);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m.mode;
    mat_11 <= m.m11; mat_12 <= m.m12; mat_13 <= m.m13; mat_21 <= m.m21;
    mat_22 <= m.m22; mat_31 <= m.m31; mat_32 <= m.m32; mat_33 <= m.m33;
    pending_angles.push_back(euler_of(m));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver: random stall and comparison with the oldest expectation.
  always @(posedge clk) begin
    angles_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction");
        end else begin
          want = pending_angles.pop_front();
          checked++;
          if (want.ax !== angle_x || want.ay !== angle_y || want.az !== angle_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                       want.ax, want.ay, want.az, angle_x, angle_y, angle_z);
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  // Directed rows: expected angles typed where obvious, otherwise predicted.
  typedef struct {
    matrix_t m;
    bit      known;
    angles_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(logic md, logic [EW-1:0] a11, a12, a13, a21, a22, a31,
                         a32, a33, bit known, logic [AW-1:0] wx, wy, wz);
    row_t r;
    r.m = '{md, a11, a12, a13, a21, a22, a31, a32, a33};
    r.known = known;
    r.want = '{wx, wy, wz};
    rows.push_back(r);
  endtask

  initial begin
    angles_t p;
    // Identity gives zero angles in both orders.
    add_row(ModeXzy, One, 0, 0, 0, One, 0, 0, One, 1, 0, 0, 0);
    add_row(ModeZyx, One, 0, 0, 0, One, 0, 0, One, 1, 0, 0, 0);
    // All zero: zero denominators and zero numerators, half turn added.
    add_row(ModeXzy, 0, 0, 0, 0, 0, 0, 0, 0, 1, 21'h100000, 21'h100000, 0);
    add_row(ModeZyx, 0, 0, 0, 0, 0, 0, 0, 0, 1, 21'h100000, 0, 21'h100000);
    // Saturated asin arguments and field extremes.
    add_row(ModeXzy, One, MinEl, 0, 0, One, 0, 0, One, 0, 0, 0, 0);
    add_row(ModeXzy, One, MaxEl, 0, 0, One, 0, 0, One, 0, 0, 0, 0);
    add_row(ModeZyx, One, 0, 0, 0, One, MinEl, 0, One, 0, 0, 0, 0);
    add_row(ModeZyx, One, 0, 0, 0, One, MaxEl, 0, One, 0, 0, 0, 0);
    add_row(ModeXzy, MaxEl, MaxEl, MaxEl, MaxEl, MaxEl, MaxEl, MaxEl, MaxEl, 0, 0, 0, 0);
    add_row(ModeZyx, MinEl, MinEl, MinEl, MinEl, MinEl, MinEl, MinEl, MinEl, 0, 0, 0, 0);
    add_row(ModeXzy, MinEl, One, MaxEl, 0, MinEl, 0, MinEl, 0, 0, 0, 0, 0);
    add_row(ModeZyx, MaxEl, 0, 0, MinEl, 0, -One, MaxEl, MinEl, 0, 0, 0, 0);
    // Zero denominators with signed numerators; negative denominators.
    add_row(ModeXzy, 0, 0, One, 0, 0, 0, -One, 0, 0, 0, 0, 0);
    add_row(ModeZyx, 0, 0, 0, One, 0, 0, -One, 0, 0, 0, 0, 0);
    add_row(ModeXzy, -One, 18'sd32768, 18'sd1000, 0, -One, 0, -18'sd1000, 0, 0, 0, 0, 0);
    add_row(ModeZyx, -One, 0, 0, 18'sd500, 0, 18'sd32768, 18'sd700, -One, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      p = euler_of(rows[i].m);
      if (rows[i].known && (p.ax !== rows[i].want.ax || p.ay !== rows[i].want.ay ||
                            p.az !== rows[i].want.az)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: predictor disagrees", i);
      end
      send(rows[i].m);
    end

    // Random matrices, with one long stretch free of idling on both sides.
    for (int i = 0; i < RandomItems; i++) begin
      quiet_stretch = (i >= 150 && i < 250);
      send(random_matrix());
    end
    quiet_stretch = 0;
    in_valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
    $display("Checked %0d angle triples from %0d directed and %0d random matrices.",
             checked, rows.size(), RandomItems);
    if (mismatches == 0) begin
      $display("[rotation_matrix_to_euler_angles_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[rotation_matrix_to_euler_angles_top] ERROR");
    end
    $finish;
  end
endmodule
